### design/smm_pkg.sv
// Shared widths, register map and sequencer states for the matrix multiplier.
package smm_pkg;

    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int RESULT_W  = 35;
    localparam int ROW_W     = 3;
    localparam int CFG_W     = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic REG_MATRIX_SIZE = 1'b0;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_ACC  = 4'b1000
    } t_state;

endpackage

### design/square_matrix_multiply.sv
// Square signed matrix multiplier with a single shared multiply-accumulate unit.
// Loading: one element pair per cycle while busy is low, N*N transactions per load.
// Compute: each product term goes through the store read, multiply and accumulate states in turn.
// Results are one-cycle strobes in row-major order; the receiver cannot stall.
// Synchronous active-low reset clears load count, sequencer and strobe; size resets to MAX_SIZE.
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_SIZE = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [VALUE_W-1:0]  i_a_value,
    input  logic signed [VALUE_W-1:0]  i_b_value,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_product_value,
    output logic [ROW_W-1:0]           o_out_row,
    output logic [ROW_W-1:0]           o_out_col,
    output logic                       o_is_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int TOT_W = 2 * CNT_W;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_cfg;
    logic [AW-1:0]             r_load_count;
    logic [CNT_W-1:0]          r_r;
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_j;
    logic [AW-1:0]             r_row_base;
    logic [AW-1:0]             r_a_addr;
    logic [AW-1:0]             r_b_addr;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [RESULT_W-1:0] r_acc;

    logic [CNT_W-1:0]          eff;
    logic [TOT_W-1:0]          total;
    logic                      accept;
    logic                      cfg_wr;
    logic                      load_done;
    logic                      last_r;
    logic                      last_j;
    logic                      last_i;
    logic [IDX_W-1:0]          idx_max;
    logic [AW-1:0]             n_row_base;
    logic signed [RESULT_W-1:0] sum;
    logic [VALUE_W-1:0]        rd_a;
    logic [VALUE_W-1:0]        rd_b;

    always_comb begin
        if (r_cfg == '0) begin
            eff = CNT_W'(1);
        end else if (r_cfg > CFG_W'(MAX_SIZE)) begin
            eff = CNT_W'(MAX_SIZE);
        end else begin
            eff = CNT_W'(r_cfg);
        end
    end

    assign total      = TOT_W'(eff) * TOT_W'(eff);
    assign busy       = (r_state != S_LOAD);
    assign accept     = start && !busy;
    assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE);
    assign load_done  = (TOT_W'(r_load_count) + TOT_W'(1)) == total;
    assign idx_max    = IDX_W'(eff - CNT_W'(1));
    assign last_r     = (r_r == eff - CNT_W'(1));
    assign last_j     = (r_j == idx_max);
    assign last_i     = (r_i == idx_max);
    assign n_row_base = AW'(r_row_base + AW'(eff));
    assign sum        = r_acc + RESULT_W'(r_prod);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(r_cfg) : '0;

    smm_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (accept),
        .i_wr_addr   (r_load_count),
        .i_wr_a      (i_a_value),
        .i_wr_b      (i_b_value),
        .i_rd_addr_a (r_a_addr),
        .i_rd_addr_b (r_b_addr),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_cfg        <= CFG_W'(MAX_SIZE);
            r_load_count <= '0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (cfg_wr) begin
                r_cfg        <= pwdata[CFG_W-1:0];
                r_load_count <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (load_done) begin
                            r_load_count <= '0;
                            r_state      <= S_READ;
                        end else begin
                            r_load_count <= AW'(r_load_count + AW'(1));
                        end
                    end
                end
                S_READ: r_state <= S_MUL;
                S_MUL:  r_state <= S_ACC;
                S_ACC: begin
                    if (last_r) begin
                        o_valid <= 1'b1;
                        r_state <= (last_i && last_j) ? S_LOAD : S_READ;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // operand address walk and accumulation
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_r        <= '0;
                r_i        <= '0;
                r_j        <= '0;
                r_row_base <= '0;
                r_a_addr   <= '0;
                r_b_addr   <= '0;
                r_acc      <= '0;
            end
            S_READ: ;
            S_MUL: r_prod <= $signed(rd_a) * $signed(rd_b);
            S_ACC: begin
                if (!last_r) begin
                    r_acc    <= sum;
                    r_r      <= CNT_W'(r_r + CNT_W'(1));
                    r_a_addr <= AW'(r_a_addr + AW'(1));
                    r_b_addr <= AW'(r_b_addr + AW'(eff));
                end else begin
                    r_acc           <= '0;
                    r_r             <= '0;
                    o_product_value <= sum;
                    o_out_row       <= ROW_W'(r_i);
                    o_out_col       <= ROW_W'(r_j);
                    o_is_last       <= last_i && last_j;
                    if (!last_j) begin
                        r_j      <= IDX_W'(r_j + IDX_W'(1));
                        r_a_addr <= r_row_base;
                        r_b_addr <= AW'(r_j) + AW'(1);
                    end else begin
                        r_j        <= '0;
                        r_b_addr   <= '0;
                        r_i        <= IDX_W'(r_i + IDX_W'(1));
                        r_row_base <= n_row_base;
                        r_a_addr   <= n_row_base;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

### design/smm_store.sv
// Operand stores for A and B: one write port, one registered read port each.
module smm_store
    import smm_pkg::*;
#(
    parameter int AW    = 6,
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [VALUE_W-1:0] i_wr_a,
    input  logic [VALUE_W-1:0] i_wr_b,
    input  logic [AW-1:0]      i_rd_addr_a,
    input  logic [AW-1:0]      i_rd_addr_b,
    output logic [VALUE_W-1:0] o_rd_a,
    output logic [VALUE_W-1:0] o_rd_b
);

    logic [VALUE_W-1:0] r_mem_a [DEPTH];
    logic [VALUE_W-1:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_a[i_wr_addr] <= i_wr_a;
            r_mem_b[i_wr_addr] <= i_wr_b;
        end
        o_rd_a <= r_mem_a[i_rd_addr_a];
        o_rd_b <= r_mem_b[i_rd_addr_b];
    end

endmodule

### design/smm_checker.sv
// Port-level checks on the result strobe sequence, bound to the top level.
module smm_checker
    import smm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_valid,
    input logic [ROW_W-1:0] o_out_row,
    input logic [ROW_W-1:0] o_out_col,
    input logic             o_is_last
);

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes on consecutive cycles");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> !busy)
        else $error("still busy after final result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |-> busy)
        else $error("idle before final result");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> (o_out_row == o_out_col))
        else $error("final result off the diagonal");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .busy      (busy),
    .o_valid   (o_valid),
    .o_out_row (o_out_row),
    .o_out_col (o_out_col),
    .o_is_last (o_is_last)
);
